// ----- rtl/lrafsm_pkg.sv -----
`default_nettype none
package lrafsm_pkg;

  localparam int CMD_W        = 3;
  localparam int BYTE_W       = 8;
  localparam int SEQ_W        = 4;
  localparam int PHASE_W      = 3;
  localparam int TIMEOUT_W    = 16;
  localparam int CFG_IDX_W    = 8;
  localparam int CFG_DATA_W   = 16;
  localparam int TIMER_W_DEF  = 16;

  // event codes carried in the cmd field
  localparam logic [CMD_W-1:0] CMD_FRAME     = 3'd0;
  localparam logic [CMD_W-1:0] CMD_FRAME_ERR = 3'd1;
  localparam logic [CMD_W-1:0] CMD_TICK      = 3'd2;
  localparam logic [CMD_W-1:0] CMD_SEND      = 3'd3;
  localparam logic [CMD_W-1:0] CMD_WAIT      = 3'd4;
  localparam logic [CMD_W-1:0] CMD_POWER_ON  = 3'd5;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ACK_CODE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT  = 8'd1;

  localparam logic [BYTE_W-1:0]    ACK_CODE_RST     = 8'd127;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST      = 16'd1000;
  localparam logic [BYTE_W-1:0]    POWERUP_DONE_CMD = 8'hf4;

  typedef enum logic [PHASE_W-1:0] {
    PH_OFF     = 3'd0,
    PH_POWERUP = 3'd1,
    PH_READY   = 3'd2,
    PH_ACK     = 3'd3,
    PH_RESP    = 3'd4,
    PH_RREADY  = 3'd5,
    PH_ERROR   = 3'd6
  } phase_t;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [BYTE_W-1:0] frame_command;
    logic [BYTE_W-1:0] frame_first_byte;
    logic [BYTE_W-1:0] frame_last_byte;
    logic [BYTE_W-1:0] tx_command;
    logic [BYTE_W-1:0] awaited_reply;
  } item_t;

  typedef struct packed {
    logic [PHASE_W-1:0] link_state;
    logic               send_ack;
    logic [BYTE_W-1:0]  ack_for_command;
    logic [SEQ_W-1:0]   ack_sequence;
    logic               start_send;
    logic               timed_out;
  } result_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] wdata;
  } cfg_t;

endpackage
`default_nettype wire

// ----- rtl/lrafsm_stream_if.sv -----
`default_nettype none
interface lrafsm_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/link_request_ack_response_fsm_unit.sv -----
`default_nettype none
// Host-side stop-and-wait handshake tracker for a modem command link. Each word
// on item is one event (frame received, frame error, tick, send/wait request,
// power on) and yields exactly one word on result: the link phase after the event,
// an ack request with the frame command and sequence nibble, a start-send flag
// and a timeout flag. One word per clock is taken and one result per clock is
// given while the result side is ready; a word is caught in an input register
// at the edge that takes it and its result is then registered in the result
// register, from which it is presented. The state update is a single pass of
// compares and one timer increment; the input stalls only while both registers
// hold words and the result side is not ready. Configuration writes take effect
// at once and must only be issued while the block is idle.
module link_request_ack_response_fsm_unit
  import lrafsm_pkg::*;
#(
  parameter int TIMER_WIDTH = TIMER_W_DEF
) (
  input  wire                  clk,
  input  wire                  rst,
  lrafsm_stream_if.sink        item,
  lrafsm_stream_if.source      result,
  lrafsm_stream_if.sink        cfg
);

  localparam int CMP_W = (TIMER_WIDTH > TIMEOUT_W) ? TIMER_WIDTH : TIMEOUT_W;

  // configuration
  logic [BYTE_W-1:0]    ack_code;
  logic [TIMEOUT_W-1:0] timeout_ticks;

  // input register
  logic  s1_valid;
  item_t s1;
  logic  s1_adv;

  // link state
  phase_t                 phase, phase_next;
  logic [BYTE_W-1:0]      sent_cmd, sent_cmd_next;
  logic [BYTE_W-1:0]      awaited_cmd, awaited_cmd_next;
  logic                   timer_run, timer_run_next;
  logic [TIMER_WIDTH-1:0] timer_cnt, timer_cnt_next;
  logic [TIMER_WIDTH-1:0] timer_inc;
  logic                   expired;

  // result register
  logic    out_valid;
  result_t out_data;
  logic    ack, start_send, tout;

  assign cfg.ready    = 1'b1;
  assign s1_adv       = s1_valid && (!out_valid || result.ready);
  assign item.ready   = !s1_valid || s1_adv;
  assign result.valid = out_valid;
  assign result.data  = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      ack_code      <= ACK_CODE_RST;
      timeout_ticks <= TIMEOUT_RST;
    end else if (cfg.valid) begin
      case (cfg.data.idx)
        REG_ACK_CODE: ack_code <= cfg.data.wdata[BYTE_W-1:0];
        REG_TIMEOUT:  timeout_ticks <= cfg.data.wdata[TIMEOUT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item.ready) begin
      s1_valid <= item.valid;
    end
    if (item.valid && item.ready) begin
      s1 <= item.data;
    end
  end

  // saturating count, expiry on reaching the limit or saturation
  assign timer_inc = (timer_cnt != '1) ? timer_cnt + TIMER_WIDTH'(1) : timer_cnt;
  assign expired   = (CMP_W'(timer_inc) >= CMP_W'(timeout_ticks)) || (timer_inc == '1);

  always_comb begin
    phase_next       = phase;
    sent_cmd_next    = sent_cmd;
    awaited_cmd_next = awaited_cmd;
    timer_run_next   = timer_run;
    timer_cnt_next   = timer_cnt;
    ack              = 1'b0;
    start_send       = 1'b0;
    tout             = 1'b0;
    case (s1.cmd)
      CMD_FRAME: begin
        case (phase)
          PH_POWERUP: begin
            if (s1.frame_command == POWERUP_DONE_CMD) begin
              timer_run_next = 1'b0;
              timer_cnt_next = '0;
              phase_next     = PH_READY;
            end
          end
          PH_ACK: begin
            if (s1.frame_command == ack_code) begin
              // ack for a different command leaves the timer running
              if (s1.frame_first_byte != sent_cmd) begin
                phase_next = PH_ERROR;
              end else begin
                timer_run_next = 1'b1;
                timer_cnt_next = '0;
                phase_next     = PH_RESP;
              end
            end else begin
              ack            = 1'b1;
              timer_run_next = 1'b1;
              timer_cnt_next = '0;
            end
          end
          PH_RESP: begin
            ack = 1'b1;
            if (s1.frame_command == awaited_cmd) begin
              timer_run_next = 1'b0;
              timer_cnt_next = '0;
              phase_next     = PH_RREADY;
            end else begin
              timer_run_next = 1'b1;
              timer_cnt_next = '0;
            end
          end
          PH_RREADY: begin
            timer_run_next = 1'b0;
            timer_cnt_next = '0;
          end
          default: ;
        endcase
      end
      CMD_FRAME_ERR: begin
        timer_run_next = 1'b0;
        timer_cnt_next = '0;
        phase_next     = PH_ERROR;
      end
      CMD_TICK: begin
        if (timer_run) begin
          if (expired) begin
            timer_run_next = 1'b0;
            timer_cnt_next = '0;
            phase_next     = PH_ERROR;
            tout           = 1'b1;
          end else begin
            timer_cnt_next = timer_inc;
          end
        end
      end
      CMD_SEND: begin
        sent_cmd_next    = s1.tx_command;
        awaited_cmd_next = s1.awaited_reply;
        phase_next       = PH_ACK;
        timer_run_next   = 1'b1;
        timer_cnt_next   = '0;
        start_send       = 1'b1;
      end
      CMD_WAIT: begin
        awaited_cmd_next = s1.awaited_reply;
        phase_next       = PH_RESP;
        timer_run_next   = 1'b1;
        timer_cnt_next   = '0;
      end
      CMD_POWER_ON: begin
        phase_next     = PH_POWERUP;
        timer_run_next = 1'b1;
        timer_cnt_next = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_OFF;
      sent_cmd    <= '0;
      awaited_cmd <= '0;
      timer_run   <= 1'b0;
      timer_cnt   <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (s1_adv) begin
        phase       <= phase_next;
        sent_cmd    <= sent_cmd_next;
        awaited_cmd <= awaited_cmd_next;
        timer_run   <= timer_run_next;
        timer_cnt   <= timer_cnt_next;
        out_valid   <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
    if (s1_adv) begin
      out_data.link_state      <= phase_next;
      out_data.send_ack        <= ack;
      out_data.ack_for_command <= ack ? s1.frame_command : '0;
      out_data.ack_sequence    <= ack ? s1.frame_last_byte[SEQ_W-1:0] : '0;
      out_data.start_send      <= start_send;
      out_data.timed_out       <= tout;
    end
  end

`ifndef SYNTH
  a_ack_send_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.send_ack && out_data.start_send))
    else $error("ack request and command send in the same result");

  a_tout_error: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.timed_out |-> out_data.link_state == PH_ERROR)
    else $error("timeout without error phase");

  a_ack_phase: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.send_ack |->
      (out_data.link_state == PH_ACK || out_data.link_state == PH_RESP ||
       out_data.link_state == PH_RREADY))
    else $error("ack request outside an exchange");

  a_timer_idle: assert property (@(posedge clk) disable iff (rst)
    !timer_run |-> timer_cnt == '0)
    else $error("timer count nonzero while stopped");

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv |=> s1_valid && $stable(s1))
    else $error("input word lost while result stalled");
`endif

endmodule
`default_nettype wire
